// ===== hw/rtl/pllm_pkg.sv =====
// Shared types and codes for the pooled linked list manager.
// No dependencies; used by pllm_out_reg, pooled_linked_list_manager_top and the bench.
package pllm_pkg;

    // operation codes carried in s_tuser
    localparam logic [2:0] KIND_APPEND = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_DUMP   = 3'd4;

    // status codes carried in m_tuser
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_ALLOC,
        S_APP_WALK,
        S_INS_WALK,
        S_INS_LINK,
        S_DEL_HEAD,
        S_DEL_WALK,
        S_CLR_WALK,
        S_DUMP_WALK,
        S_RESULT
    } pllm_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic        last;
    } pllm_result_t;

endpackage

// ===== hw/rtl/pooled_linked_list_manager_top.sv =====
// Top level of the pooled linked list manager: sequencer, node pool memories, head.
// Depends on pllm_pkg and pllm_out_reg.
//
// One singly linked list of 32-bit values lives in a pool of POOL_NODES nodes. After reset
// the free map is swept once, one node per cycle, before the first transaction is taken.
// Each operation is then handled alone: the sequencer walks the list one node per cycle
// through the single read port of the node memory (a dump walk holds while the output
// stage is full), and a first-fit allocation scans the free map one node per cycle.
module pooled_linked_list_manager_top
#(
    parameter int POOL_NODES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] value, [63:32] key
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data_out
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int IW = $clog2(POOL_NODES + 1);
    localparam int NW = $clog2(POOL_NODES);
    localparam logic [IW-1:0] NO_NODE   = IW'(POOL_NODES);
    localparam logic [IW-1:0] LAST_NODE = IW'(POOL_NODES - 1);

    // node pool
    logic [31:0]   value_mem [POOL_NODES];
    logic [IW-1:0] link_mem  [POOL_NODES];
    logic          free_mem  [POOL_NODES];

    logic [31:0]   rd_value_reg;
    logic [IW-1:0] rd_link_reg;
    logic          rd_free_reg;

    logic          value_we;
    logic [NW-1:0] value_waddr;
    logic [31:0]   value_wdata;
    logic          link_we;
    logic [NW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;
    logic          free_we;
    logic [NW-1:0] free_waddr;
    logic          free_wdata;

    pllm_pkg::pllm_state_t state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] new_reg, new_next;
    logic [IW-1:0] steps_reg, steps_next;
    logic [1:0]    status_reg, status_next;
    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   value_reg, value_next;
    logic [31:0]   key_reg, key_next;

    logic          push_valid;
    logic          push_ready;
    pllm_pkg::pllm_result_t push_result;
    pllm_pkg::pllm_result_t out_result;

    logic [IW-1:0] rd_next;
    logic          head_none;
    logic          accept;

    assign rd_next   = (rd_link_reg >= NO_NODE) ? NO_NODE : rd_link_reg;
    assign head_none = (head_reg >= NO_NODE);
    assign s_tready  = (state_reg == pllm_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // memories: one write and one registered read per array; read address is cur_next (new_next for the free map)
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        rd_value_reg <= value_mem[cur_next[NW-1:0]];
        rd_link_reg  <= link_mem[cur_next[NW-1:0]];
        rd_free_reg  <= free_mem[new_next[NW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pllm_pkg::S_SWEEP;
            head_reg  <= NO_NODE;
            new_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            new_reg   <= new_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        key_reg    <= key_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        new_next    = new_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        key_next    = key_reg;

        value_we    = 1'b0;
        value_waddr = new_reg[NW-1:0];
        value_wdata = value_reg;
        link_we     = 1'b0;
        link_waddr  = new_reg[NW-1:0];
        link_wdata  = NO_NODE;
        free_we     = 1'b0;
        free_waddr  = new_reg[NW-1:0];
        free_wdata  = 1'b0;

        push_valid         = 1'b0;
        push_result.status = status_reg;
        push_result.data   = '0;
        push_result.last   = 1'b1;

        case (state_reg)
            pllm_pkg::S_SWEEP:
            begin
                free_we    = 1'b1;
                free_wdata = 1'b1;
                if (new_reg == LAST_NODE)
                begin
                    new_next   = '0;
                    state_next = pllm_pkg::S_IDLE;
                end
                else
                begin
                    new_next = new_reg + IW'(1);
                end
            end

            pllm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = s_tuser;
                    value_next = s_tdata[31:0];
                    key_next   = s_tdata[63:32];
                    cur_next   = head_reg;
                    steps_next = '0;
                    case (s_tuser)
                        pllm_pkg::KIND_APPEND:
                        begin
                            new_next   = '0;
                            state_next = pllm_pkg::S_ALLOC;
                        end
                        pllm_pkg::KIND_INSERT,
                        pllm_pkg::KIND_DELETE:
                        begin
                            if (head_none)
                            begin
                                status_next = pllm_pkg::STAT_NOT_FOUND;
                                state_next  = pllm_pkg::S_RESULT;
                            end
                            else if (s_tuser == pllm_pkg::KIND_INSERT)
                            begin
                                state_next = pllm_pkg::S_INS_WALK;
                            end
                            else
                            begin
                                state_next = pllm_pkg::S_DEL_HEAD;
                            end
                        end
                        pllm_pkg::KIND_CLEAR:
                        begin
                            if (head_none)
                            begin
                                head_next   = NO_NODE;
                                status_next = pllm_pkg::STAT_OK;
                                state_next  = pllm_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = pllm_pkg::S_CLR_WALK;
                            end
                        end
                        pllm_pkg::KIND_DUMP:
                        begin
                            if (head_none)
                            begin
                                status_next = pllm_pkg::STAT_EMPTY;
                                state_next  = pllm_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = pllm_pkg::S_DUMP_WALK;
                            end
                        end
                        default:
                        begin
                            // unused kind: drop the transaction
                            state_next = pllm_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            pllm_pkg::S_ALLOC:
            begin
                // rd_free_reg holds the free flag of node new_reg
                if (rd_free_reg)
                begin
                    free_we     = 1'b1;
                    free_wdata  = 1'b0;
                    value_we    = 1'b1;
                    link_we     = 1'b1;
                    if (kind_reg == pllm_pkg::KIND_APPEND)
                    begin
                        link_wdata = NO_NODE;
                        if (head_none)
                        begin
                            head_next   = new_reg;
                            status_next = pllm_pkg::STAT_OK;
                            state_next  = pllm_pkg::S_RESULT;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            steps_next = '0;
                            state_next = pllm_pkg::S_APP_WALK;
                        end
                    end
                    else
                    begin
                        link_wdata = prev_reg;
                        state_next = pllm_pkg::S_INS_LINK;
                    end
                end
                else if (new_reg == LAST_NODE)
                begin
                    status_next = pllm_pkg::STAT_FULL;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else
                begin
                    new_next = new_reg + IW'(1);
                end
            end

            pllm_pkg::S_APP_WALK:
            begin
                if (rd_next == NO_NODE || steps_reg == NO_NODE)
                begin
                    link_we     = 1'b1;
                    link_waddr  = cur_reg[NW-1:0];
                    link_wdata  = new_reg;
                    status_next = pllm_pkg::STAT_OK;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else
                begin
                    cur_next   = rd_next;
                    steps_next = steps_reg + IW'(1);
                end
            end

            pllm_pkg::S_INS_WALK:
            begin
                if (rd_value_reg == key_reg)
                begin
                    // remember the successor, then take a node
                    prev_next  = rd_next;
                    new_next   = '0;
                    state_next = pllm_pkg::S_ALLOC;
                end
                else if (rd_next == NO_NODE || steps_reg == LAST_NODE)
                begin
                    status_next = pllm_pkg::STAT_NOT_FOUND;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else
                begin
                    cur_next   = rd_next;
                    steps_next = steps_reg + IW'(1);
                end
            end

            pllm_pkg::S_INS_LINK:
            begin
                link_we     = 1'b1;
                link_waddr  = cur_reg[NW-1:0];
                link_wdata  = new_reg;
                status_next = pllm_pkg::STAT_OK;
                state_next  = pllm_pkg::S_RESULT;
            end

            pllm_pkg::S_DEL_HEAD:
            begin
                if (rd_value_reg == value_reg)
                begin
                    head_next   = rd_next;
                    free_we     = 1'b1;
                    free_waddr  = cur_reg[NW-1:0];
                    free_wdata  = 1'b1;
                    status_next = pllm_pkg::STAT_OK;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else if (rd_next == NO_NODE)
                begin
                    status_next = pllm_pkg::STAT_NOT_FOUND;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_next;
                    steps_next = '0;
                    state_next = pllm_pkg::S_DEL_WALK;
                end
            end

            pllm_pkg::S_DEL_WALK:
            begin
                if (rd_value_reg == value_reg)
                begin
                    // unlink cur from prev and free it
                    link_we     = 1'b1;
                    link_waddr  = prev_reg[NW-1:0];
                    link_wdata  = rd_next;
                    free_we     = 1'b1;
                    free_waddr  = cur_reg[NW-1:0];
                    free_wdata  = 1'b1;
                    status_next = pllm_pkg::STAT_OK;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else if (rd_next == NO_NODE || steps_reg == LAST_NODE)
                begin
                    status_next = pllm_pkg::STAT_NOT_FOUND;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_next;
                    steps_next = steps_reg + IW'(1);
                end
            end

            pllm_pkg::S_CLR_WALK:
            begin
                free_we    = 1'b1;
                free_waddr = cur_reg[NW-1:0];
                free_wdata = 1'b1;
                if (rd_next == NO_NODE || steps_reg == LAST_NODE)
                begin
                    head_next   = NO_NODE;
                    status_next = pllm_pkg::STAT_OK;
                    state_next  = pllm_pkg::S_RESULT;
                end
                else
                begin
                    cur_next   = rd_next;
                    steps_next = steps_reg + IW'(1);
                end
            end

            pllm_pkg::S_DUMP_WALK:
            begin
                push_valid         = 1'b1;
                push_result.status = pllm_pkg::STAT_OK;
                push_result.data   = rd_value_reg;
                push_result.last   = (rd_next == NO_NODE) || (steps_reg == LAST_NODE);
                // hold cur while the output stage is full
                if (push_ready)
                begin
                    if (push_result.last)
                    begin
                        state_next = pllm_pkg::S_IDLE;
                    end
                    else
                    begin
                        cur_next   = rd_next;
                        steps_next = steps_reg + IW'(1);
                    end
                end
            end

            pllm_pkg::S_RESULT:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = pllm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pllm_pkg::S_IDLE;
            end
        endcase
    end

    pllm_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_result (push_result),
        .push_ready  (push_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = out_result.data;
    assign m_tuser = out_result.status;
    assign m_tlast = out_result.last;

endmodule

// ===== hw/rtl/pllm_out_reg.sv =====
// Output register stage for result transactions.
// Depends on pllm_pkg for the result record.
module pllm_out_reg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  pllm_pkg::pllm_result_t push_result,
    output logic                  push_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output pllm_pkg::pllm_result_t out_result
);

    logic                   valid_reg;
    pllm_pkg::pllm_result_t result_reg;

    // take a new result when empty or when the held one leaves this cycle
    assign push_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            result_reg <= push_result;
        end
    end

endmodule

// ===== bench/tb_pooled_linked_list_manager_top.sv =====
// Self-checking bench for pooled_linked_list_manager_top: directed and random list operations,
// predicted by a behavioral copy of the node pool and compared on every result transaction.
// Depends on pllm_pkg and the RTL of the pooled linked list manager.
module tb_pooled_linked_list_manager_top;

    localparam int         POOL           = 16;
    localparam logic [4:0] NIL            = 5'd16;
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
    localparam int         RANDOM_OPS     = 180;
    localparam int         LONG_HOLD      = 300;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [31:0] key;
        bit          drain;
    } list_op_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [31:0] value, [63:32] key
    logic [2:0]  s_tuser  = '0;    // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] data_out
    logic [1:0]  m_tuser;          // [1:0] status
    logic        m_tlast;

    // behavioral copy of the pool
    logic [31:0] pool_val  [POOL];
    logic [4:0]  pool_next [POOL];
    bit          pool_free [POOL];
    logic [4:0]  head;

    list_op_t               op_queue[$];
    list_op_t               nxt;
    pllm_pkg::pllm_result_t due_results[$];

    int items_in       = 0;
    int results_seen   = 0;
    int fails          = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int kind_seen [8];
    int stat_seen [4];

    wire quiet = (items_in >= 120) && (items_in < 160);

    pooled_linked_list_manager_top #(.POOL_NODES(POOL)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    function automatic logic [4:0] follow(input logic [4:0] n);
        if (n >= NIL)
            return NIL;
        return (pool_next[n[3:0]] >= NIL) ? NIL : pool_next[n[3:0]];
    endfunction

    // first-fit from node 0
    function automatic logic [4:0] grab_node();
        for (int i = 0; i < POOL; i++)
        begin
            if (pool_free[i])
            begin
                pool_free[i] = 1'b0;
                return 5'(i);
            end
        end
        return NIL;
    endfunction

    task automatic owe(input logic [1:0] st, input logic [31:0] data, input logic fin);
        pllm_pkg::pllm_result_t r;
        r.status = st;
        r.data   = data;
        r.last   = fin;
        due_results.push_back(r);
    endtask

    task automatic apply_list_op(input logic [2:0] kind, input logic [31:0] value,
                                 input logic [31:0] key);
        logic [4:0] cur;
        logic [4:0] nx;
        logic [4:0] n;
        logic [1:0] st;
        int         steps;
        int         k;
        bit         done;
        cur  = (head >= NIL) ? NIL : head;
        done = 1'b0;
        case (kind)
            pllm_pkg::KIND_APPEND:
            begin
                n = grab_node();
                if (n == NIL)
                    st = pllm_pkg::STAT_FULL;
                else
                begin
                    st = pllm_pkg::STAT_OK;
                    pool_val[n[3:0]]  = value;
                    pool_next[n[3:0]] = NIL;
                    if (head >= NIL)
                        head = n;
                    else
                    begin
                        steps = 0;
                        while (steps < POOL && follow(cur) != NIL)
                        begin
                            cur = follow(cur);
                            steps++;
                        end
                        pool_next[cur[3:0]] = n;
                    end
                end
                owe(st, '0, 1'b1);
            end
            pllm_pkg::KIND_INSERT:
            begin
                st = pllm_pkg::STAT_NOT_FOUND;
                for (steps = 0; steps < POOL && cur != NIL && !done; steps++)
                begin
                    if (pool_val[cur[3:0]] == key)
                    begin
                        done = 1'b1;
                        n = grab_node();
                        if (n == NIL)
                            st = pllm_pkg::STAT_FULL;
                        else
                        begin
                            st = pllm_pkg::STAT_OK;
                            pool_val[n[3:0]]    = value;
                            pool_next[n[3:0]]   = follow(cur);
                            pool_next[cur[3:0]] = n;
                        end
                    end
                    else
                        cur = follow(cur);
                end
                owe(st, '0, 1'b1);
            end
            pllm_pkg::KIND_DELETE:
            begin
                st = pllm_pkg::STAT_NOT_FOUND;
                if (cur != NIL)
                begin
                    if (pool_val[cur[3:0]] == value)
                    begin
                        head                = follow(cur);
                        pool_free[cur[3:0]] = 1'b1;
                        st                  = pllm_pkg::STAT_OK;
                    end
                    else
                    begin
                        for (steps = 0; steps < POOL && !done; steps++)
                        begin
                            nx = follow(cur);
                            if (nx == NIL)
                                done = 1'b1;
                            else if (pool_val[nx[3:0]] == value)
                            begin
                                pool_next[cur[3:0]] = follow(nx);
                                pool_free[nx[3:0]]  = 1'b1;
                                st                  = pllm_pkg::STAT_OK;
                                done                = 1'b1;
                            end
                            else
                                cur = nx;
                        end
                    end
                end
                owe(st, '0, 1'b1);
            end
            pllm_pkg::KIND_CLEAR:
            begin
                for (steps = 0; steps < POOL && cur != NIL; steps++)
                begin
                    pool_free[cur[3:0]] = 1'b1;
                    cur = follow(cur);
                end
                head = NIL;
                owe(pllm_pkg::STAT_OK, '0, 1'b1);
            end
            pllm_pkg::KIND_DUMP:
            begin
                if (cur == NIL)
                    owe(pllm_pkg::STAT_EMPTY, '0, 1'b1);
                else
                begin
                    k = 0;
                    while (cur != NIL && k < POOL)
                    begin
                        nx = follow(cur);
                        owe(pllm_pkg::STAT_OK, pool_val[cur[3:0]],
                            (nx == NIL) || (k + 1 >= POOL));
                        cur = nx;
                        k++;
                    end
                end
            end
            default:
            begin
                // spare kinds: no result, no state change
            end
        endcase
    endtask

    task automatic add_op(input logic [2:0] kind, input logic [31:0] value,
                          input logic [31:0] key, input bit drain = 1'b0);
        list_op_t op;
        op.kind  = kind;
        op.value = value;
        op.key   = key;
        op.drain = drain;
        op_queue.push_back(op);
    endtask

    // mostly a small set of values so keys and deletes hit, sometimes full-range
    function automatic logic [31:0] pick_value();
        logic [31:0] common [8];
        common = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0005, 32'h0000_0011, 32'h5555_5555, 32'hAAAA_AAAA};
        if ($urandom_range(0, 99) < 70)
            return common[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_kind();
        int w;
        w = $urandom_range(0, 99);
        if (w < 40)
            return pllm_pkg::KIND_APPEND;
        if (w < 60)
            return pllm_pkg::KIND_INSERT;
        if (w < 80)
            return pllm_pkg::KIND_DELETE;
        if (w < 92)
            return pllm_pkg::KIND_DUMP;
        return pllm_pkg::KIND_CLEAR;
    endfunction

    // clear, overfill, hit and miss on a full pool, dump a full list
    task automatic add_fill_burst(input bit drain);
        logic [31:0] first_val;
        logic [31:0] v;
        first_val = pick_value();
        add_op(pllm_pkg::KIND_CLEAR, $urandom, $urandom, drain);
        add_op(pllm_pkg::KIND_APPEND, first_val, $urandom);
        for (int i = 0; i < POOL; i++)
        begin
            v = pick_value();
            add_op(pllm_pkg::KIND_APPEND, v, $urandom);
        end
        add_op(pllm_pkg::KIND_INSERT, pick_value(), first_val);
        add_op(pllm_pkg::KIND_INSERT, pick_value(), $urandom);
        add_op(pllm_pkg::KIND_DUMP, $urandom, $urandom);
        add_op(pllm_pkg::KIND_DELETE, first_val, $urandom);
        add_op(pllm_pkg::KIND_DUMP, $urandom, $urandom);
        add_op(pllm_pkg::KIND_APPEND, pick_value(), $urandom);
        add_op(pllm_pkg::KIND_INSERT, pick_value(), pick_value());
    endtask

    task automatic build_stimulus();
        int n_ops;
        int len;
        int sel;
        logic [2:0] kd;
        // directed
        add_op(pllm_pkg::KIND_DUMP,   32'h0, 32'h0);
        add_op(pllm_pkg::KIND_DELETE, 32'h0, 32'h0);
        add_op(pllm_pkg::KIND_INSERT, 32'h1, 32'h0);
        add_op(KIND_SPARE_LO, 32'h0, 32'h0);
        add_op(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(pllm_pkg::KIND_APPEND, 32'h8000_0000, 32'h0);
        add_op(pllm_pkg::KIND_APPEND, 32'h7FFF_FFFF, 32'h0);
        add_op(pllm_pkg::KIND_APPEND, 32'h0000_0000, 32'h0);
        add_op(pllm_pkg::KIND_APPEND, 32'hFFFF_FFFF, 32'h0);
        add_op(pllm_pkg::KIND_INSERT, 32'h0000_1234, 32'h7FFF_FFFF);
        add_op(pllm_pkg::KIND_INSERT, 32'h0000_0055, 32'h8000_0000);
        add_op(pllm_pkg::KIND_INSERT, 32'h0000_0066, 32'h0BAD_CAFE);
        add_op(pllm_pkg::KIND_DUMP,   32'h0, 32'h0);
        add_op(pllm_pkg::KIND_DELETE, 32'h8000_0000, 32'h0);
        add_op(pllm_pkg::KIND_DELETE, 32'h0000_0000, 32'h0);
        add_op(pllm_pkg::KIND_DELETE, 32'hFFFF_FFFF, 32'h0);
        add_op(pllm_pkg::KIND_DELETE, 32'h1357_9BDF, 32'h0);
        add_op(pllm_pkg::KIND_DUMP,   32'h0, 32'h0);
        add_op(pllm_pkg::KIND_CLEAR,  32'h0, 32'h0);
        add_op(pllm_pkg::KIND_DUMP,   32'h0, 32'h0);
        add_op(pllm_pkg::KIND_CLEAR,  32'h0, 32'h0);

        // random: sender waits for every result before the first burst
        add_fill_burst(1'b1);
        n_ops = 46;
        while (n_ops < RANDOM_OPS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                len = $urandom_range(6, 12);
                for (int i = 0; i < len; i++)
                    add_op(pick_kind(), pick_value(), pick_value(),
                           $urandom_range(0, 49) == 0);
                n_ops += len;
            end
            else if (sel == 7)
            begin
                add_fill_burst(1'b0);
                n_ops += 25;
            end
            else
            begin
                len = $urandom_range(3, 6);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 1) == 1)
                        add_op(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                               $urandom, $urandom);
                    else
                    begin
                        kd = pick_kind();
                        add_op(kd, $urandom, $urandom);
                    end
                    n_ops++;
                end
            end
        end
    endtask

    // sender; a drain item also waits for the transaction accepted at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (op_queue.size() > 0
                && !(op_queue[0].drain && (s_tvalid || due_results.size() > 0))
                && (quiet || $urandom_range(0, 99) >= 33))
            begin
                nxt = op_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.key, nxt.value};
                s_tuser  <= nxt.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!long_hold_done && items_in >= 40)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= 33);
    end

    // predict on each input transaction, then check each output transaction
    always @(posedge clk)
    begin
        pllm_pkg::pllm_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_list_op(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                kind_seen[s_tuser]++;
                items_in++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                stat_seen[m_tuser]++;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: status %0d data_out %h last %b",
                           m_tuser, m_tdata, m_tlast);
                    fails++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fails++;
                    end
                    if (m_tdata !== want.data)
                    begin
                        $error("data_out: expected %h, got %h", want.data, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < POOL; i++)
        begin
            pool_val[i]  = '0;
            pool_next[i] = '0;
            pool_free[i] = 1'b1;
        end
        head = NIL;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() > 0 || s_tvalid)
            @(negedge clk);
        while (due_results.size() > 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (due_results.size() > 0)
        begin
            $error("%0d results never arrived", due_results.size());
            fails++;
        end
        $display("run: %0d ops (append %0d, insert %0d, delete %0d, clear %0d, dump %0d)",
                 items_in, kind_seen[pllm_pkg::KIND_APPEND],
                 kind_seen[pllm_pkg::KIND_INSERT], kind_seen[pllm_pkg::KIND_DELETE],
                 kind_seen[pllm_pkg::KIND_CLEAR], kind_seen[pllm_pkg::KIND_DUMP]);
        $display("results: %0d (ok %0d, not found %0d, pool full %0d, empty %0d), %0d errors",
                 results_seen, stat_seen[pllm_pkg::STAT_OK],
                 stat_seen[pllm_pkg::STAT_NOT_FOUND], stat_seen[pllm_pkg::STAT_FULL],
                 stat_seen[pllm_pkg::STAT_EMPTY], fails);
        if (fails == 0)
            $display("** pooled_linked_list_manager_top: PASSED **");
        else
            $display("** pooled_linked_list_manager_top: FAILED **");
        $finish;
    end

    initial
    begin
        #(20 * 400000);
        $display("** pooled_linked_list_manager_top: FAILED **");
        $finish;
    end

endmodule

// ===== pooled_linked_list_manager_top.f =====
hw/rtl/pllm_pkg.sv
hw/rtl/pllm_out_reg.sv
hw/rtl/pooled_linked_list_manager_top.sv
bench/tb_pooled_linked_list_manager_top.sv
